FILE: sv/tmeq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timed MIDI event queue package
// Word types of the request and response channels, the stored entry layout,
// and the codes shared by the queue logic.
// ----------------------------------------------------------------------------
package tmeq_pkg;

   // Function codes of a request word.
   localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [1:0] FUNC_TICK     = 2'd1;
   localparam logic [1:0] FUNC_CLEAR    = 2'd2;

   // Control register indexes.
   localparam logic CSR_ROUTE_EXT = 1'b0;
   localparam logic CSR_ROUTE_INT = 1'b1;

   // A tick releases at most this many entries.
   localparam int MAX_RELEASE = 32;
   localparam int RelW        = 6;

   // Status byte masks.
   localparam logic [7:0] STATUS_MASK  = 8'hF0;
   localparam logic [7:0] CHANNEL_MASK = 8'h0F;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now_ms;
      logic [31:0] delay_ms;
      logic [3:0]  channel;
      logic [1:0]  msg_len;
      logic [7:0]  msg_byte0;
      logic [7:0]  msg_byte1;
      logic [7:0]  msg_byte2;
      logic        synth_ready;
   } req_word_type;

   typedef struct packed {
      logic [1:0] out_len;
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic       to_external;
      logic       to_internal;
      logic [5:0] remaining_count;
      logic       last;
   } rsp_word_type;

   // Stored message: length in the low bits, then the three bytes.
   typedef struct packed {
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
      logic [1:0] len;
   } msg_type;

   typedef struct packed {
      logic [31:0] due;
      msg_type     msg;
   } entry_type;

endpackage
`default_nettype wire

FILE: sv/timed_midi_event_queue.sv
`default_nettype none
// A clear, a dropped schedule or an unused code is done in idle. A schedule moves each
// later entry up one slot from the tail until an earlier entry or the head ends the walk.
// A tick releases due entries from the head until one is not yet due, the queue is empty
// or MAX_RELEASE is reached; output stalls hold it. Memory reads are registered, and one
// request word is in work at a time. Reset empties the queue and sets routing to external
// on, internal off; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// Timed MIDI event queue
// Keeps scheduled MIDI messages in due-time order in a circular memory and
// releases those that are due on a tick, earliest first.
// ----------------------------------------------------------------------------
module timed_midi_event_queue
   import tmeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic         csr_wdata
);

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS_RD   = 3'd1;
   localparam logic [2:0] S_INS_CHK  = 3'd2;
   localparam logic [2:0] S_TICK_RD  = 3'd3;
   localparam logic [2:0] S_TICK_CHK = 3'd4;
   localparam logic [2:0] S_TICK_FIN = 3'd5;

   // Map a head-relative sum back into the memory range.
   function automatic logic [IdxW-1:0] wrap_idx(input logic [IdxW:0] s);
      logic [IdxW:0] r;
      begin
         r = s;
         if (s >= (IdxW+1)'(QUEUE_DEPTH)) begin
            r = s - (IdxW+1)'(QUEUE_DEPTH);
         end
         return r[IdxW-1:0];
      end
   endfunction

   logic [2:0]      state_ff, state_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] pos_ff, pos_in;
   entry_type       ins_ff, ins_in;
   logic [31:0]     now_ff, now_in;
   logic            to_ext_ff, to_ext_in;
   logic            to_int_ff, to_int_in;
   logic [RelW-1:0] rel_n_ff, rel_n_in;
   logic            pend_ff, pend_in;
   msg_type         pend_msg_ff, pend_msg_in;
   logic [5:0]      pend_rem_ff, pend_rem_in;
   logic            route_ext_ff, route_int_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_word_type    rsp_ff, rsp_in;

   entry_type       mem [QUEUE_DEPTH];
   entry_type       rd_q;
   logic            mem_re, mem_we;
   logic [IdxW-1:0] rd_addr, wr_addr;
   entry_type       wr_data;

   logic            req_take;
   logic            out_free;
   msg_type         new_msg;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Build the stored form of a scheduled message.
   always_comb begin
      new_msg.len   = req_data.msg_len;
      new_msg.byte0 = (req_data.msg_len == 2'd0) ? 8'h00 :
                      ((req_data.msg_byte0 & STATUS_MASK) |
                       ({4'h0, req_data.channel} & CHANNEL_MASK));
      new_msg.byte1 = (req_data.msg_len >= 2'd2) ? req_data.msg_byte1 : 8'h00;
      new_msg.byte2 = (req_data.msg_len == 2'd3) ? req_data.msg_byte2 : 8'h00;
   end

   // Sequencer for insertion walks and release walks.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      ins_in       = ins_ff;
      now_in       = now_ff;
      to_ext_in    = to_ext_ff;
      to_int_in    = to_int_ff;
      rel_n_in     = rel_n_ff;
      pend_in      = pend_ff;
      pend_msg_in  = pend_msg_ff;
      pend_rem_in  = pend_rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = head_ff;
      wr_addr      = wrap_idx({1'b0, head_ff} + (IdxW+1)'(pos_ff));
      wr_data      = ins_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_data.func)
                  FUNC_SCHEDULE: begin
                     if (count_ff < CntW'(QUEUE_DEPTH)) begin
                        ins_in.due = req_data.now_ms + req_data.delay_ms;
                        ins_in.msg = new_msg;
                        pos_in     = count_ff;
                        state_in   = S_INS_RD;
                     end
                  end
                  FUNC_TICK: begin
                     now_in    = req_data.now_ms;
                     to_ext_in = route_ext_ff;
                     to_int_in = route_int_ff && req_data.synth_ready;
                     rel_n_in  = '0;
                     pend_in   = 1'b0;
                     state_in  = S_TICK_RD;
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Look at the entry just before the open slot.
         S_INS_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_re   = 1'b1;
               rd_addr  = wrap_idx({1'b0, head_ff} + (IdxW+1)'(pos_ff - 1'b1));
               state_in = S_INS_CHK;
            end
         end

         // A later entry moves up one slot; otherwise the new one lands here.
         S_INS_CHK: begin
            mem_we = 1'b1;
            if (rd_q.due > ins_ff.due) begin
               wr_data  = rd_q;
               pos_in   = pos_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end
         end

         S_TICK_RD: begin
            if (count_ff == '0 || rel_n_ff == RelW'(MAX_RELEASE)) begin
               state_in = S_TICK_FIN;
            end else begin
               mem_re   = 1'b1;
               state_in = S_TICK_CHK;
            end
         end

         // The head entry is due: send the held one and hold this one, so that
         // the last word of the tick can be marked.
         S_TICK_CHK: begin
            if (rd_q.due > now_ff) begin
               state_in = S_TICK_FIN;
            end else if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{out_len: pend_msg_ff.len, out_byte0: pend_msg_ff.byte0,
                             out_byte1: pend_msg_ff.byte1, out_byte2: pend_msg_ff.byte2,
                             to_external: to_ext_ff, to_internal: to_int_ff,
                             remaining_count: pend_rem_ff, last: 1'b0};
               end
               pend_in     = 1'b1;
               pend_msg_in = rd_q.msg;
               count_in    = count_ff - 1'b1;
               pend_rem_in = 6'(count_ff - 1'b1);
               head_in     = wrap_idx({1'b0, head_ff} + (IdxW+1)'(1));
               rel_n_in    = rel_n_ff + 1'b1;
               state_in    = S_TICK_RD;
            end
         end

         S_TICK_FIN: begin
            if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{out_len: pend_msg_ff.len, out_byte0: pend_msg_ff.byte0,
                          out_byte1: pend_msg_ff.byte1, out_byte2: pend_msg_ff.byte2,
                          to_external: to_ext_ff, to_internal: to_int_ff,
                          remaining_count: pend_rem_ff, last: 1'b1};
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_q <= mem[rd_addr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rel_n_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rel_n_ff     <= rel_n_in;
      end
   end

   // Routing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         route_ext_ff <= 1'b1;
         route_int_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROUTE_EXT: route_ext_ff <= csr_wdata;
            CSR_ROUTE_INT: route_int_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      ins_ff      <= ins_in;
      now_ff      <= now_in;
      to_ext_ff   <= to_ext_in;
      to_int_ff   <= to_int_in;
      pend_msg_ff <= pend_msg_in;
      pend_rem_ff <= pend_rem_in;
      rsp_ff      <= rsp_in;
   end

   // The fill count stays within the memory.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // No held release survives the end of a tick.
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_ff)
      else $error("held release left over in idle");

   // The memory is never read and written in the same cycle.
   a_mem_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_re && mem_we))
      else $error("memory read and write overlap");

   // A new response word is loaded only when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled response word overwritten");

   // Releases per tick stay within the limit.
   a_rel_limit: assert property (@(posedge clock) disable iff (reset)
      rel_n_ff <= RelW'(MAX_RELEASE))
      else $error("too many releases in one tick");

endmodule
`default_nettype wire
